@@ hw/rtl/rrip_dip_stream_dead_replacement_top_assert.svh @@
// Assertion macros for the checker file of the replacement block.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef RRIP_DIP_STREAM_DEAD_REPLACEMENT_TOP_ASSERT_SVH
`define RRIP_DIP_STREAM_DEAD_REPLACEMENT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDSD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rdsd_pkg.sv @@
// ----------------------------------------------------------------------------
// rdsd_pkg
// Types and codes shared by the replacement policy modules.
// ----------------------------------------------------------------------------
package rdsd_pkg;

    // Replacement state of one way.
    typedef struct packed {
        logic       valid;
        logic [1:0] dead;
        logic [1:0] rrpv;
    } entry_t;

    // Per-set state: last address, stream counter and leader kind.
    typedef struct packed {
        logic [47:0] last_address;
        logic [1:0]  stream_count;
        logic [1:0]  leader_kind;
    } set_entry_t;

    localparam logic [1:0] KIND_FOLLOWER = 2'd0;
    localparam logic [1:0] KIND_LIP      = 2'd1;
    localparam logic [1:0] KIND_BIP      = 2'd2;

    localparam logic ACT_QUERY  = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    localparam logic [1:0] REG_STRIDE_LIMIT     = 2'd0;
    localparam logic [1:0] REG_STREAM_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_DEAD_THRESHOLD   = 2'd2;
    localparam logic [1:0] REG_DECAY_SHIFT      = 2'd3;

    localparam logic [1:0] RRPV_MAX = 2'd3;

    typedef enum logic [1:0] {
        ROW_QUERY,
        ROW_UPDATE,
        ROW_DECAY
    } row_op_t;

    // Control from the sequencer to the row logic.
    typedef struct packed {
        row_op_t    op;
        logic       hit;
        logic       streaming;
        logic [1:0] dead_limit;
        logic [1:0] policy_rrpv;
    } row_ctrl_t;

    // Status from the row logic back to the sequencer.
    typedef struct packed {
        logic bypassed;
        logic dead_pred;
    } row_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_LEADER,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP
    } state_t;

endpackage

@@ hw/rtl/rdsd_ram.sv @@
// ----------------------------------------------------------------------------
// rdsd_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module rdsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/rdsd_row_logic.sv @@
// ----------------------------------------------------------------------------
// rdsd_row_logic
// Read-modify-write logic for one set row: victim search, update and decay.
// ----------------------------------------------------------------------------
module rdsd_row_logic #(
    parameter int WAY_COUNT = 16
) (
    input  rdsd_pkg::entry_t [WAY_COUNT-1:0] row_in,
    input  logic [$clog2(WAY_COUNT)-1:0]     way,
    input  rdsd_pkg::row_ctrl_t              ctrl,
    output rdsd_pkg::entry_t [WAY_COUNT-1:0] row_out,
    output logic [$clog2(WAY_COUNT)-1:0]     victim,
    output rdsd_pkg::row_status_t            status
);

    localparam int WAY_W = $clog2(WAY_COUNT);

    logic [3:0]       any_all;
    logic [3:0]       any_valid;
    logic [1:0]       top_all;
    logic [1:0]       top_valid;
    logic [1:0]       age;
    logic [WAY_W-1:0] first_top;
    logic [WAY_W-1:0] last_valid_top;
    rdsd_pkg::entry_t sel;
    logic [1:0]       dead_m;

    always_comb
    begin
        any_all   = '0;
        any_valid = '0;
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            any_all[row_in[w].rrpv] = 1'b1;
            if (row_in[w].valid)
            begin
                any_valid[row_in[w].rrpv] = 1'b1;
            end
        end
        top_all   = any_all[3] ? 2'd3 : any_all[2] ? 2'd2 : any_all[1] ? 2'd1 : 2'd0;
        top_valid = any_valid[3] ? 2'd3 : any_valid[2] ? 2'd2 : any_valid[1] ? 2'd1 : 2'd0;
        age       = rdsd_pkg::RRPV_MAX - top_all;

        first_top      = '0;
        last_valid_top = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--)
        begin
            if (row_in[w].rrpv == top_all)
            begin
                first_top = WAY_W'(w);
            end
        end
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            if (row_in[w].valid && (row_in[w].rrpv == top_valid))
            begin
                last_valid_top = WAY_W'(w);
            end
        end

        sel    = row_in[way];
        dead_m = (sel.valid && (sel.dead != 2'd3)) ? sel.dead + 2'd1 : sel.dead;

        status.dead_pred = (dead_m >= ctrl.dead_limit);
        status.bypassed  = 1'b0;
        row_out          = row_in;
        victim           = '0;

        unique case (ctrl.op)
            rdsd_pkg::ROW_QUERY:
            begin
                if (ctrl.streaming)
                begin
                    victim = last_valid_top;
                end
                else
                begin
                    victim = first_top;
                    for (int w = 0; w < WAY_COUNT; w++)
                    begin
                        row_out[w].rrpv = row_in[w].rrpv + age;
                    end
                end
            end
            rdsd_pkg::ROW_UPDATE:
            begin
                if (ctrl.hit)
                begin
                    row_out[way] = '{valid: 1'b1, dead: 2'd0, rrpv: 2'd0};
                end
                else if (ctrl.streaming)
                begin
                    row_out[way]    = '{valid: 1'b0, dead: dead_m, rrpv: sel.rrpv};
                    status.bypassed = 1'b1;
                end
                else
                begin
                    row_out[way] = '{valid: 1'b1, dead: 2'd0,
                                     rrpv: status.dead_pred ? rdsd_pkg::RRPV_MAX
                                                            : ctrl.policy_rrpv};
                end
            end
            rdsd_pkg::ROW_DECAY:
            begin
                for (int w = 0; w < WAY_COUNT; w++)
                begin
                    if (row_in[w].dead != 2'd0)
                    begin
                        row_out[w].dead = row_in[w].dead - 2'd1;
                    end
                end
            end
            default:
            begin
                row_out = row_in;
            end
        endcase
    end

endmodule

@@ hw/rtl/rrip_dip_stream_dead_replacement_top.sv @@
// ----------------------------------------------------------------------------
// rrip_dip_stream_dead_replacement_top
// RRIP replacement with dead-block prediction, stream bypass and LIP/BIP
// set dueling for a last-level cache.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                          Direction
// --------  -----------------------------------------------  ---------
// request   start, busy, action, set_index, way_index,       in
//           address, hit
// result    done, victim_way, bypassed                       out
// config    wr_en, wr_index, wr_data                         in
//
// A request transfer happens when start is high and busy is low. The request
// is read from both memories in that cycle, and the next cycle modifies the
// rows and writes them back; the row memory has a registered read.
// The result shows on done for exactly one cycle, in the cycle after the write
// back; the receiver cannot stall it.
// After reset the block sweeps all SET_COUNT rows to their reset value and
// then writes 2*LEADER_PAIRS leader marks; busy stays high until both are
// done. Configuration writes are taken anyway.
// A miss update that is not bypassed and lands on a decay boundary is
// followed by a decay sweep over all rows during which busy is high.
//
module rrip_dip_stream_dead_replacement_top #(
    parameter int SET_COUNT     = 2048,
    parameter int WAY_COUNT     = 16,
    parameter int LEADER_PAIRS  = 32,
    parameter int SELECTOR_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [10:0] set_index,
    input  logic [3:0]  way_index,
    input  logic [47:0] address,
    input  logic        hit,
    output logic        done,
    output logic [3:0]  victim_way,
    output logic        bypassed,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data
);

    localparam int IDX_W   = $clog2(SET_COUNT);
    localparam int WAY_W   = $clog2(WAY_COUNT);
    localparam int CNT_W   = IDX_W + 1;
    localparam int LEAD_W  = $clog2(2 * LEADER_PAIRS);
    localparam int ROW_W   = WAY_COUNT * $bits(rdsd_pkg::entry_t);
    localparam int SET_W   = $bits(rdsd_pkg::set_entry_t);
    localparam int SET_RED = (12 - $clog2(SET_COUNT)) > 0 ? (12 - $clog2(SET_COUNT)) : 1;
    localparam int WAY_RED = (5 - $clog2(WAY_COUNT)) > 0 ? (5 - $clog2(WAY_COUNT)) : 1;

    localparam logic [SELECTOR_BITS-1:0] SEL_MAX = SELECTOR_BITS'((1 << SELECTOR_BITS) - 1);
    localparam logic [SELECTOR_BITS-1:0] SEL_MID = SELECTOR_BITS'(((1 << SELECTOR_BITS) - 1) / 2);

    // Leader positions are walked backwards: the last write of a set is then
    // the first claim in forward order, which is the one that wins.
    localparam int A_STEP  = 37 % SET_COUNT;
    localparam int B_STEP  = 71 % SET_COUNT;
    localparam int A_START = (37 * (LEADER_PAIRS - 1)) % SET_COUNT;
    localparam int B_START = (71 * (LEADER_PAIRS - 1) + 13) % SET_COUNT;

    // Set index modulo SET_COUNT by a few conditional subtractions.
    function automatic logic [IDX_W-1:0] reduce_set(input logic [10:0] v);
        logic [31:0] r;
        r = 32'(v);
        for (int k = SET_RED - 1; k >= 0; k--)
        begin
            if (r >= (32'(SET_COUNT) << k))
            begin
                r = r - (32'(SET_COUNT) << k);
            end
        end
        return r[IDX_W-1:0];
    endfunction

    // Way index modulo WAY_COUNT, same scheme.
    function automatic logic [WAY_W-1:0] reduce_way(input logic [3:0] v);
        logic [31:0] r;
        r = 32'(v);
        for (int k = WAY_RED - 1; k >= 0; k--)
        begin
            if (r >= (32'(WAY_COUNT) << k))
            begin
                r = r - (32'(WAY_COUNT) << k);
            end
        end
        return r[WAY_W-1:0];
    endfunction

    // Step a leader position back by one pair, modulo SET_COUNT.
    function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] v,
                                                   input int step);
        logic [IDX_W:0] r;
        if ({1'b0, v} >= (IDX_W + 1)'(step))
        begin
            r = {1'b0, v} - (IDX_W + 1)'(step);
        end
        else
        begin
            r = {1'b0, v} + (IDX_W + 1)'(SET_COUNT) - (IDX_W + 1)'(step);
        end
        return r[IDX_W-1:0];
    endfunction

    // Configuration registers.
    logic [15:0] stride_limit_reg;
    logic [1:0]  stream_threshold_reg;
    logic [1:0]  dead_limit_reg;
    logic [4:0]  decay_shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_limit_reg     <= 16'd1024;
            stream_threshold_reg <= 2'd2;
            dead_limit_reg       <= 2'd2;
            decay_shift_reg      <= 5'd13;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                rdsd_pkg::REG_STRIDE_LIMIT:     stride_limit_reg     <= wr_data;
                rdsd_pkg::REG_STREAM_THRESHOLD: stream_threshold_reg <= wr_data[1:0];
                rdsd_pkg::REG_DEAD_THRESHOLD:   dead_limit_reg       <= wr_data[1:0];
                rdsd_pkg::REG_DECAY_SHIFT:      decay_shift_reg      <= wr_data[4:0];
                default:                        stride_limit_reg     <= stride_limit_reg;
            endcase
        end
    end

    // Sequencer state.
    rdsd_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LEAD_W-1:0] lead_reg, lead_next;
    logic [IDX_W-1:0]  a_pos_reg, a_pos_next;
    logic [IDX_W-1:0]  b_pos_reg, b_pos_next;
    logic [SELECTOR_BITS-1:0] sel_reg, sel_next;
    logic [19:0] access_reg, access_next;
    logic [4:0]  lphase_reg, lphase_next;
    logic [4:0]  fphase_reg, fphase_next;

    // Captured request.
    logic             action_reg;
    logic [IDX_W-1:0] set_reg;
    logic [WAY_W-1:0] way_reg;
    logic [47:0]      addr_reg;
    logic             hit_reg;

    // Result register.
    logic       done_reg, done_next;
    logic [3:0] victim_reg, victim_next;
    logic       bypass_reg, bypass_next;

    // Memory ports.
    logic                                row_we, row_re, set_we, set_re;
    logic [IDX_W-1:0]                    row_waddr, row_raddr, set_waddr, set_raddr;
    rdsd_pkg::entry_t [WAY_COUNT-1:0]    row_wdata, row_rdata, row_mod, row_reset;
    rdsd_pkg::set_entry_t                set_wdata, set_rdata;

    logic                  accept;
    rdsd_pkg::row_ctrl_t   ctrl;
    rdsd_pkg::row_status_t status;
    logic [WAY_W-1:0]      victim_w;

    // Stride and dueling terms of the request in flight.
    logic [47:0] diff;
    logic        stride_hit;
    logic [1:0]  stream_new;
    logic        streaming;
    logic        bip_follow;
    logic        is_update;
    logic        miss_alloc;
    logic [4:0]  shift_eff;
    logic [19:0] decay_mask;
    logic        decay_due;

    assign accept = start && (state_reg == rdsd_pkg::ST_IDLE);
    assign busy   = (state_reg != rdsd_pkg::ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            set_reg    <= reduce_set(set_index);
            way_reg    <= reduce_way(way_index);
            addr_reg   <= address;
            hit_reg    <= hit;
        end
    end

    always_comb
    begin
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            row_reset[w] = '{valid: 1'b0, dead: 2'd0, rrpv: rdsd_pkg::RRPV_MAX};
        end
    end

    // Stream tracking: a small positive stride counts up, anything else down; no change while the last address is zero.
    always_comb
    begin
        is_update  = (action_reg == rdsd_pkg::ACT_UPDATE);
        diff       = addr_reg - set_rdata.last_address;
        stride_hit = (addr_reg > set_rdata.last_address) && (diff < {32'd0, stride_limit_reg});
        stream_new = set_rdata.stream_count;
        if (set_rdata.last_address != 48'd0)
        begin
            if (stride_hit)
            begin
                if (set_rdata.stream_count != 2'd3)
                begin
                    stream_new = set_rdata.stream_count + 2'd1;
                end
            end
            else if (set_rdata.stream_count != 2'd0)
            begin
                stream_new = set_rdata.stream_count - 2'd1;
            end
        end
        streaming = is_update ? (stream_new >= stream_threshold_reg)
                              : (set_rdata.stream_count >= stream_threshold_reg);
        bip_follow = (sel_reg >= SEL_MID);

        ctrl.hit        = hit_reg;
        ctrl.streaming  = streaming;
        ctrl.dead_limit = dead_limit_reg;
        unique case (set_rdata.leader_kind)
            rdsd_pkg::KIND_LIP:
                ctrl.policy_rrpv = rdsd_pkg::RRPV_MAX;
            rdsd_pkg::KIND_BIP:
                ctrl.policy_rrpv = (lphase_reg == 5'd0) ? 2'd0 : rdsd_pkg::RRPV_MAX;
            rdsd_pkg::KIND_FOLLOWER:
                ctrl.policy_rrpv = (bip_follow && (fphase_reg == 5'd0)) ? 2'd0
                                                                        : rdsd_pkg::RRPV_MAX;
            default:
                ctrl.policy_rrpv = rdsd_pkg::RRPV_MAX;
        endcase
        if (state_reg == rdsd_pkg::ST_EXEC)
        begin
            ctrl.op = is_update ? rdsd_pkg::ROW_UPDATE : rdsd_pkg::ROW_QUERY;
        end
        else
        begin
            ctrl.op = rdsd_pkg::ROW_DECAY;
        end

        miss_alloc = is_update && !hit_reg && !streaming;

        // Decay every 2^decay_shift update accesses, the shift clamped to 1..20.
        shift_eff = (decay_shift_reg == 5'd0) ? 5'd1
                  : (decay_shift_reg > 5'd20) ? 5'd20 : decay_shift_reg;
        decay_mask = ~(20'hFFFFF << shift_eff);
        decay_due  = (((access_reg + 20'd1) & decay_mask) == 20'd0);
    end

    rdsd_row_logic #(
        .WAY_COUNT (WAY_COUNT)
    ) u_row_logic (
        .row_in  (row_rdata),
        .way     (way_reg),
        .ctrl    (ctrl),
        .row_out (row_mod),
        .victim  (victim_w),
        .status  (status)
    );

    // Sequencer: next state, counters, memory controls and result.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        lead_next   = lead_reg;
        a_pos_next  = a_pos_reg;
        b_pos_next  = b_pos_reg;
        sel_next    = sel_reg;
        access_next = access_reg;
        lphase_next = lphase_reg;
        fphase_next = fphase_reg;
        done_next   = 1'b0;
        victim_next = victim_reg;
        bypass_next = bypass_reg;

        row_we    = 1'b0;
        row_waddr = cnt_reg[IDX_W-1:0];
        row_wdata = row_mod;
        row_re    = 1'b0;
        row_raddr = reduce_set(set_index);
        set_we    = 1'b0;
        set_waddr = cnt_reg[IDX_W-1:0];
        set_wdata = '0;
        set_re    = 1'b0;
        set_raddr = reduce_set(set_index);

        unique case (state_reg)
            rdsd_pkg::ST_CLEAR:
            begin
                row_we    = 1'b1;
                row_wdata = row_reset;
                set_we    = 1'b1;
                if (cnt_reg == CNT_W'(SET_COUNT - 1))
                begin
                    state_next = rdsd_pkg::ST_LEADER;
                    lead_next  = '0;
                    a_pos_next = IDX_W'(A_START);
                    b_pos_next = IDX_W'(B_START);
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            rdsd_pkg::ST_LEADER:
            begin
                set_we = 1'b1;
                if (!lead_reg[0])
                begin
                    set_waddr             = b_pos_reg;
                    set_wdata.leader_kind = rdsd_pkg::KIND_BIP;
                end
                else
                begin
                    set_waddr             = a_pos_reg;
                    set_wdata.leader_kind = rdsd_pkg::KIND_LIP;
                    a_pos_next            = step_back(a_pos_reg, A_STEP);
                    b_pos_next            = step_back(b_pos_reg, B_STEP);
                end
                if (lead_reg == LEAD_W'(2 * LEADER_PAIRS - 1))
                begin
                    state_next = rdsd_pkg::ST_IDLE;
                end
                else
                begin
                    lead_next = lead_reg + LEAD_W'(1);
                end
            end
            rdsd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    row_re     = 1'b1;
                    set_re     = 1'b1;
                    state_next = rdsd_pkg::ST_EXEC;
                end
            end
            rdsd_pkg::ST_EXEC:
            begin
                row_we    = 1'b1;
                row_waddr = set_reg;
                set_waddr = set_reg;
                set_wdata = '{last_address: addr_reg, stream_count: stream_new,
                              leader_kind: set_rdata.leader_kind};
                set_we    = is_update;
                done_next   = 1'b1;
                victim_next = is_update ? 4'd0 : 4'(victim_w);
                bypass_next = status.bypassed;
                state_next  = rdsd_pkg::ST_IDLE;
                if (is_update)
                begin
                    access_next = access_reg + 20'd1;
                end
                if (miss_alloc)
                begin
                    if (!status.dead_pred)
                    begin
                        if (set_rdata.leader_kind == rdsd_pkg::KIND_BIP)
                        begin
                            lphase_next = lphase_reg + 5'd1;
                        end
                        else if ((set_rdata.leader_kind == rdsd_pkg::KIND_FOLLOWER) &&
                                 bip_follow)
                        begin
                            fphase_next = fphase_reg + 5'd1;
                        end
                    end
                    if ((set_rdata.leader_kind == rdsd_pkg::KIND_LIP) && (sel_reg != SEL_MAX))
                    begin
                        sel_next = sel_reg + SELECTOR_BITS'(1);
                    end
                    else if ((set_rdata.leader_kind == rdsd_pkg::KIND_BIP) &&
                             (sel_reg != '0))
                    begin
                        sel_next = sel_reg - SELECTOR_BITS'(1);
                    end
                    if (decay_due)
                    begin
                        state_next = rdsd_pkg::ST_SWEEP;
                        cnt_next   = '0;
                    end
                end
            end
            rdsd_pkg::ST_SWEEP:
            begin
                // Read row cnt while the decayed row cnt-1 is written back.
                row_re    = 1'b1;
                row_raddr = cnt_reg[IDX_W-1:0];
                row_we    = (cnt_reg != '0);
                row_waddr = IDX_W'(cnt_reg - CNT_W'(1));
                if (cnt_reg == CNT_W'(SET_COUNT))
                begin
                    state_next = rdsd_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = rdsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rdsd_pkg::ST_CLEAR;
            cnt_reg    <= '0;
            lead_reg   <= '0;
            a_pos_reg  <= '0;
            b_pos_reg  <= '0;
            sel_reg    <= SEL_MID;
            access_reg <= '0;
            lphase_reg <= '0;
            fphase_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            lead_reg   <= lead_next;
            a_pos_reg  <= a_pos_next;
            b_pos_reg  <= b_pos_next;
            sel_reg    <= sel_next;
            access_reg <= access_next;
            lphase_reg <= lphase_next;
            fphase_reg <= fphase_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        victim_reg <= victim_next;
        bypass_reg <= bypass_next;
    end

    assign done       = done_reg;
    assign victim_way = victim_reg;
    assign bypassed   = bypass_reg;

    // Row memory: the replacement state of all ways of a set in one word.
    rdsd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SET_COUNT)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    // Set memory: stride tracking and leader kind.
    rdsd_ram #(
        .WIDTH (SET_W),
        .DEPTH (SET_COUNT)
    ) u_set_ram (
        .clk   (clk),
        .we    (set_we),
        .waddr (set_waddr),
        .wdata (set_wdata),
        .re    (set_re),
        .raddr (set_raddr),
        .rdata (set_rdata)
    );

endmodule

@@ hw/rtl/rdsd_checker.sv @@
// ----------------------------------------------------------------------------
// rdsd_checker
// Port-level assertions for the replacement block, bound to the top level.
// ----------------------------------------------------------------------------
`include "rrip_dip_stream_dead_replacement_top_assert.svh"

module rdsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [3:0] victim_way,
    input logic       bypassed
);

    // A query never reports a bypass and an update never names a victim, so no result has both.
    `RDSD_ASSERT_IMPLY(a_result_kind, done, (victim_way == 4'd0) || !bypassed, "bad result mix")

    // An accepted transfer keeps the block busy in the following cycle.
    `RDSD_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "not busy after accept")

    // Every result follows an accepted transfer, through the execute state and the done register.
    `RDSD_ASSERT_IMPLY(a_done_latency, done, $past(start && !busy, 2), "result without request")

    // Results never come in back-to-back cycles.
    `RDSD_ASSERT_NEXT(a_done_single, done, !done, "result strobe too long")

endmodule

bind rrip_dip_stream_dead_replacement_top rdsd_checker u_rdsd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .victim_way (victim_way),
    .bypassed   (bypassed)
);

@@ verif/rrip_dip_stream_dead_replacement_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rrip_dip_stream_dead_replacement_checker
// Watches the request, result and configuration ports of the replacement
// block, predicts each result from its own copy of the policy state and
// compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module rrip_dip_stream_dead_replacement_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        action,
    input  logic [10:0] set_index,
    input  logic [3:0]  way_index,
    input  logic [47:0] address,
    input  logic        hit,
    input  logic        done,
    input  logic [3:0]  victim_way,
    input  logic        bypassed,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data,
    output int          fail_count,
    output int          pending
);

    localparam int SETS  = 2048;
    localparam int WAYS  = 16;
    localparam int PAIRS = 32;
    localparam logic [9:0] SEL_MAX = 10'h3FF;
    localparam logic [9:0] SEL_MID = 10'd511;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       bypassed;
    } verdict_t;

    logic [1:0]  rrpv_mem     [SETS*WAYS];
    logic [1:0]  dead_mem     [SETS*WAYS];
    logic        valid_mem    [SETS*WAYS];
    logic [47:0] prev_addr_mem[SETS];
    logic [1:0]  stream_mem   [SETS];
    logic [1:0]  kind_mem     [SETS];
    logic [9:0]  selector;
    logic [19:0] access_cnt;
    logic [4:0]  leader_phase;
    logic [4:0]  follower_phase;

    logic [15:0] stride_limit;
    logic [1:0]  stream_threshold;
    logic [1:0]  dead_limit;
    logic [4:0]  decay_shift;

    verdict_t expected_q[$];

    assign pending = expected_q.size();

    function automatic logic [1:0] bip_insert(ref logic [4:0] phase);
        logic [1:0] r;
        r = (phase == 5'd0) ? 2'd0 : rdsd_pkg::RRPV_MAX;
        phase = phase + 5'd1;
        return r;
    endfunction

    task automatic predict_access(input logic act, input logic [10:0] s,
                                  input logic [3:0] w, input logic [47:0] a,
                                  input logic h, output verdict_t v);
        int base;
        int idx;
        int sh;
        logic [1:0]  top;
        logic [47:0] prev;
        logic [1:0]  ins;
        base = int'(s) * WAYS;
        idx  = base + int'(w);
        v    = '0;
        top  = 2'd0;
        if (act == rdsd_pkg::ACT_QUERY) begin
            if (stream_mem[s] >= stream_threshold) begin
                for (int i = 0; i < WAYS; i++)
                    if (valid_mem[base+i] && rrpv_mem[base+i] >= top) begin
                        top = rrpv_mem[base+i];
                        v.victim_way = 4'(i);
                    end
            end else begin
                for (int i = 0; i < WAYS; i++)
                    if (rrpv_mem[base+i] > top) top = rrpv_mem[base+i];
                for (int i = 0; i < WAYS; i++)
                    rrpv_mem[base+i] = rrpv_mem[base+i] + (rdsd_pkg::RRPV_MAX - top);
                for (int i = WAYS - 1; i >= 0; i--)
                    if (rrpv_mem[base+i] == rdsd_pkg::RRPV_MAX) v.victim_way = 4'(i);
            end
            return;
        end
        access_cnt = access_cnt + 20'd1;
        prev = prev_addr_mem[s];
        prev_addr_mem[s] = a;
        if (prev != 48'd0) begin
            if (a > prev && (a - prev) < {32'd0, stride_limit}) begin
                if (stream_mem[s] < 2'd3) stream_mem[s]++;
            end else if (stream_mem[s] > 2'd0) begin
                stream_mem[s]--;
            end
        end
        if (h) begin
            dead_mem[idx]  = 2'd0;
            rrpv_mem[idx]  = 2'd0;
            valid_mem[idx] = 1'b1;
            return;
        end
        if (valid_mem[idx] && dead_mem[idx] < 2'd3) dead_mem[idx]++;
        if (stream_mem[s] >= stream_threshold) begin
            valid_mem[idx] = 1'b0;
            v.bypassed = 1'b1;
            return;
        end
        if (dead_mem[idx] >= dead_limit)                ins = rdsd_pkg::RRPV_MAX;
        else if (kind_mem[s] == rdsd_pkg::KIND_LIP)     ins = rdsd_pkg::RRPV_MAX;
        else if (kind_mem[s] == rdsd_pkg::KIND_BIP)     ins = bip_insert(leader_phase);
        else if (selector >= SEL_MID)                   ins = bip_insert(follower_phase);
        else                                            ins = rdsd_pkg::RRPV_MAX;
        rrpv_mem[idx]  = ins;
        dead_mem[idx]  = 2'd0;
        valid_mem[idx] = 1'b1;
        if (kind_mem[s] == rdsd_pkg::KIND_LIP && selector < SEL_MAX) selector++;
        else if (kind_mem[s] == rdsd_pkg::KIND_BIP && selector > 10'd0) selector--;
        sh = int'(decay_shift);
        if (sh < 1)  sh = 1;
        if (sh > 20) sh = 20;
        if ((access_cnt & ((20'd1 << sh) - 20'd1)) == 20'd0)
            for (int i = 0; i < SETS*WAYS; i++)
                if (dead_mem[i] != 2'd0) dead_mem[i]--;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t v;
        verdict_t e;
        int a;
        int b;
        if (!rst_n) begin
            for (int i = 0; i < SETS*WAYS; i++) begin
                rrpv_mem[i]  = rdsd_pkg::RRPV_MAX;
                dead_mem[i]  = 2'd0;
                valid_mem[i] = 1'b0;
            end
            for (int i = 0; i < SETS; i++) begin
                prev_addr_mem[i] = 48'd0;
                stream_mem[i]    = 2'd0;
                kind_mem[i]      = rdsd_pkg::KIND_FOLLOWER;
            end
            for (int i = 0; i < PAIRS; i++) begin
                a = (i * 37) % SETS;
                b = (i * 71 + 13) % SETS;
                if (kind_mem[a] == rdsd_pkg::KIND_FOLLOWER) kind_mem[a] = rdsd_pkg::KIND_LIP;
                if (kind_mem[b] == rdsd_pkg::KIND_FOLLOWER) kind_mem[b] = rdsd_pkg::KIND_BIP;
            end
            selector         = SEL_MID;
            access_cnt       = 20'd0;
            leader_phase     = 5'd0;
            follower_phase   = 5'd0;
            stride_limit     = 16'd1024;
            stream_threshold = 2'd2;
            dead_limit       = 2'd2;
            decay_shift      = 5'd13;
            fail_count       = 0;
            expected_q.delete();
        end else begin
            if (done) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no prediction waiting");
                    fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    if (victim_way !== e.victim_way) begin
                        $error("victim_way: expected %0d, actual %0d", e.victim_way,
                               victim_way);
                        fail_count++;
                    end
                    if (bypassed !== e.bypassed) begin
                        $error("bypassed: expected %0d, actual %0d", e.bypassed, bypassed);
                        fail_count++;
                    end
                end
            end
            if (wr_en) begin
                case (wr_index)
                    rdsd_pkg::REG_STRIDE_LIMIT:     stride_limit     = wr_data;
                    rdsd_pkg::REG_STREAM_THRESHOLD: stream_threshold = wr_data[1:0];
                    rdsd_pkg::REG_DEAD_THRESHOLD:   dead_limit       = wr_data[1:0];
                    default:                        decay_shift      = wr_data[4:0];
                endcase
            end
            if (start && !busy) begin
                predict_access(action, set_index, way_index, address, hit, v);
                expected_q.push_back(v);
            end
        end
    end

endmodule

@@ verif/rrip_dip_stream_dead_replacement_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rrip_dip_stream_dead_replacement_top_tb
// Drives victim queries and replacement updates into the replacement block
// across several register settings; a checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module rrip_dip_stream_dead_replacement_top_tb;

    // The watchdog limit covers the clearing pass after reset and a decay
    // sweep, each a pass over all SET_COUNT rows, many times over.
    localparam int STALL_LIMIT = 50000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        action;
    logic [10:0] set_index;
    logic [3:0]  way_index;
    logic [47:0] address;
    logic        hit;
    logic        done;
    logic [3:0]  victim_way;
    logic        bypassed;
    logic        wr_en;
    logic [1:0]  wr_index;
    logic [15:0] wr_data;
    int          fail_count;
    int          pending;

    int          burst_left;
    int          sent_count;
    int          setting_count;
    int          stall_cycles;
    logic [15:0] cur_stride_limit;
    logic [10:0] stream_sets[4];
    logic [47:0] stream_addr[4];
    logic [47:0] stream_step[4];
    logic [10:0] hot_sets[8];

    rrip_dip_stream_dead_replacement_top u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .set_index(set_index), .way_index(way_index), .address(address), .hit(hit),
        .done(done), .victim_way(victim_way), .bypassed(bypassed),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    rrip_dip_stream_dead_replacement_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .set_index(set_index), .way_index(way_index), .address(address), .hit(hit),
        .done(done), .victim_way(victim_way), .bypassed(bypassed),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // The watchdog counts cycles in which neither a request nor a result
    // transfer takes place. Idle time at the end is bounded by the same limit.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("rrip_dip_stream_dead_replacement_top test failed");
                $finish;
            end
        end
    end

    // Sends one request. Requests go out in bursts with start held high
    // between them; a new burst begins after a random gap. The task returns at
    // the falling edge after the transfer, which keeps all input changes on
    // falling edges.
    task automatic send(input logic act, input logic [10:0] s, input logic [3:0] w,
                        input logic [47:0] a, input logic h);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        start     <= 1'b1;
        action    <= act;
        set_index <= s;
        way_index <= w;
        address   <= a;
        hit       <= h;
        do @(posedge clk); while (busy);
        burst_left--;
        sent_count++;
        @(negedge clk);
    endtask

    // Waits until every predicted result has arrived and any decay sweep has
    // finished, so that register writes see an idle block.
    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        while (busy) @(negedge clk);
    endtask

    // Writes all four registers on consecutive cycles, then drops the enable.
    task automatic write_settings(input logic [15:0] stride, input logic [1:0] st,
                                  input logic [1:0] dt, input logic [4:0] ds);
        drain();
        wr_en    <= 1'b1;
        wr_index <= rdsd_pkg::REG_STRIDE_LIMIT;
        wr_data  <= stride;
        @(negedge clk);
        wr_index <= rdsd_pkg::REG_STREAM_THRESHOLD;
        wr_data  <= {14'd0, st};
        @(negedge clk);
        wr_index <= rdsd_pkg::REG_DEAD_THRESHOLD;
        wr_data  <= {14'd0, dt};
        @(negedge clk);
        wr_index <= rdsd_pkg::REG_DECAY_SHIFT;
        wr_data  <= {11'd0, ds};
        @(negedge clk);
        wr_en <= 1'b0;
        cur_stride_limit = stride;
        setting_count++;
    endtask

    // Random traffic. Nearly half the items belong to address streams on a few sets, so
    // the stream counters climb and the bypass and streaming-victim paths are
    // reached; a hot set pool with random hits and misses works the RRIP,
    // dead prediction and dueling paths; the rest is noise over all fields.
    task automatic random_items(input int count);
        int pick;
        int k;
        logic [47:0] a;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                k = $urandom_range(0, 3);
                if ($urandom_range(0, 3) == 0) begin
                    send(rdsd_pkg::ACT_QUERY, stream_sets[k], 4'($urandom), 48'($urandom),
                         1'b0);
                end else begin
                    // Now and then the stream breaks with a backward jump.
                    if ($urandom_range(0, 15) == 0)
                        stream_addr[k] = stream_addr[k] - 48'($urandom_range(1, 4096));
                    else
                        stream_addr[k] = stream_addr[k] + stream_step[k];
                    send(rdsd_pkg::ACT_UPDATE, stream_sets[k], 4'($urandom), stream_addr[k],
                         $urandom_range(0, 4) == 0);
                end
            end else if (pick < 90) begin
                k = $urandom_range(0, 7);
                a = {$urandom, $urandom};
                send($urandom_range(0, 9) < 6, hot_sets[k], 4'($urandom), a,
                     $urandom_range(0, 2) == 0);
            end else begin
                a = ($urandom_range(0, 9) == 0) ? 48'd0 : {$urandom, $urandom};
                send(1'($urandom), 11'($urandom), 4'($urandom), a, 1'($urandom));
            end
        end
    endtask

    // Picks fresh stream sets and strides suited to the current stride limit.
    task automatic new_streams();
        for (int k = 0; k < 4; k++) begin
            stream_sets[k] = 11'($urandom);
            stream_addr[k] = {1'b0, 15'($urandom), $urandom};
            stream_step[k] = (cur_stride_limit > 16'd1)
                           ? 48'($urandom_range(1, int'(cur_stride_limit) - 1)) : 48'd1;
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        action     = rdsd_pkg::ACT_QUERY;
        set_index  = '0;
        way_index  = '0;
        address    = '0;
        hit        = 1'b0;
        wr_en      = 1'b0;
        wr_index   = rdsd_pkg::REG_STRIDE_LIMIT;
        wr_data    = '0;
        burst_left = 0;
        sent_count = 0;
        setting_count = 0;
        stall_cycles  = 0;
        cur_stride_limit = 16'd1024;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Hot sets include the first LIP leader (set 0), the first BIP leader
        // (set 13), the highest set and random followers.
        hot_sets[0] = 11'd0;
        hot_sets[1] = 11'd13;
        hot_sets[2] = 11'd2047;
        for (int k = 3; k < 8; k++) hot_sets[k] = 11'($urandom);

        // Directed part under reset settings: queries on an untouched set
        // (RRIP search with everything at 3), misses in a LIP leader and a BIP
        // leader, a hit then a query on the same set, and the extremes of
        // set, way and address.
        send(rdsd_pkg::ACT_QUERY,  11'd5,    4'd0,  48'd0, 1'b0);
        send(rdsd_pkg::ACT_UPDATE, 11'd0,    4'd3,  48'h100, 1'b0);
        send(rdsd_pkg::ACT_UPDATE, 11'd13,   4'd7,  48'h200, 1'b0);
        send(rdsd_pkg::ACT_UPDATE, 11'd13,   4'd8,  48'h9000, 1'b0);
        send(rdsd_pkg::ACT_UPDATE, 11'd5,    4'd15, 48'hFFFF_FFFF_FFFF, 1'b1);
        send(rdsd_pkg::ACT_QUERY,  11'd5,    4'd0,  48'd0, 1'b0);
        send(rdsd_pkg::ACT_UPDATE, 11'd2047, 4'd0,  48'd0, 1'b0);
        send(rdsd_pkg::ACT_QUERY,  11'd2047, 4'd15, 48'hFFFF_FFFF_FFFF, 1'b1);
        // A miss on a valid way raises its dead counter, but the fill clears it, so
        // the next fill of that way is not predicted dead under the reset limit.
        send(rdsd_pkg::ACT_UPDATE, 11'd300,  4'd2,  48'h5000_0000, 1'b1);
        send(rdsd_pkg::ACT_UPDATE, 11'd300,  4'd2,  48'h1000_0000, 1'b0);
        send(rdsd_pkg::ACT_UPDATE, 11'd300,  4'd2,  48'h0800_0000, 1'b0);
        // A short stream on one set: the counter reaches the threshold, then a
        // miss is bypassed and the query takes the streaming path. A stride of
        // zero and a backward stride follow.
        for (int i = 1; i <= 5; i++)
            send(rdsd_pkg::ACT_UPDATE, 11'd77, 4'(i), 48'h4000 + 48'(i * 64), i == 2);
        send(rdsd_pkg::ACT_QUERY,  11'd77, 4'd0, 48'd0, 1'b0);
        send(rdsd_pkg::ACT_UPDATE, 11'd77, 4'd1, 48'h4140, 1'b0);
        send(rdsd_pkg::ACT_UPDATE, 11'd77, 4'd1, 48'h0040, 1'b0);
        send(rdsd_pkg::ACT_QUERY,  11'd77, 4'd0, 48'd0, 1'b0);

        // Random phases over several settings, extremes included; the last
        // phase returns to the reset values.
        new_streams();
        random_items(280);

        write_settings(16'hFFFF, 2'd3, 2'd3, 5'd20);
        new_streams();
        random_items(240);

        write_settings(16'd1, 2'd0, 2'd0, 5'd13);
        new_streams();
        random_items(180);

        // Decay every second access keeps the block sweeping, so this phase
        // stays short.
        write_settings(16'd4096, 2'd1, 2'd1, 5'd1);
        new_streams();
        random_items(60);

        write_settings(16'd1024, 2'd2, 2'd2, 5'd13);
        new_streams();
        random_items(350);

        drain();
        repeat (40) @(negedge clk);

        $display("Covered %0d request transfers over %0d register settings,", sent_count,
                 setting_count + 1);
        $display("with stream bypass, leader dueling and decay sweeps exercised.");
        if (fail_count == 0 && pending == 0)
            $display("rrip_dip_stream_dead_replacement_top test passed");
        else
            $display("rrip_dip_stream_dead_replacement_top test failed");
        $finish;
    end

endmodule
